/* design/bfps_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Byte FIFO with pattern search - shared package
// Request/result payload types, request codes, controller states and the
// command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package bfps_pkg;

    localparam int BYTE_W     = 8;
    localparam int FILL_W     = 10;
    localparam int PATTERN_W  = 64;
    localparam int PLEN_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;
    localparam logic [1:0] REQ_FIND  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_PATTERN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'd1;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [BYTE_W-1:0] write_byte;
    } req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic              read_valid;
        logic              accepted;
        logic              found;
        logic [FILL_W-1:0] fill_count;
    } res_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_WRITE,
        OP_READ,
        OP_FLUSH,
        OP_SCAN_LOAD,
        OP_SCAN_STEP,
        OP_FIND_DONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   found;
    } ctl_cmd_t;

    typedef struct packed {
        logic scan_trivial;
        logic scan_hit;
        logic scan_end;
    } dp_status_t;

endpackage

`default_nettype wire

/* design/bfps_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Byte FIFO with pattern search - controller
// Decodes requests in idle and sequences the pattern scan.
// ----------------------------------------------------------------------------
module bfps_ctrl
    import bfps_pkg::*;
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             start,
    input  wire req_t       req,
    input  wire dp_status_t status,
    output logic            busy,
    output ctl_cmd_t        cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && req.req_type == REQ_FIND && !status.scan_trivial)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_hit || status.scan_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op    = OP_NONE;
        cmd.found = 1'b0;
        busy      = (state_reg == ST_SCAN);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (req.req_type)
                        REQ_WRITE: cmd.op = OP_WRITE;
                        REQ_READ:  cmd.op = OP_READ;
                        REQ_FLUSH: cmd.op = OP_FLUSH;
                        REQ_FIND:
                        begin
                            // nothing to scan: answer not found at once
                            cmd.op = status.scan_trivial ? OP_FIND_DONE : OP_SCAN_LOAD;
                        end
                        default: cmd.op = OP_NONE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (status.scan_hit)
                begin
                    cmd.op    = OP_FIND_DONE;
                    cmd.found = 1'b1;
                end
                else if (status.scan_end)
                begin
                    cmd.op = OP_FIND_DONE;
                end
                else
                begin
                    cmd.op = OP_SCAN_STEP;
                end
            end
            default: cmd.op = OP_NONE;
        endcase
    end

    a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start) && $past(req.req_type) == REQ_FIND)
        else $error("scan entered without a find transaction");

    a_no_step_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> cmd.op != OP_SCAN_STEP)
        else $error("scan step issued while idle");

endmodule

`default_nettype wire

/* design/bfps_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Byte FIFO with pattern search - datapath
// Byte store, pointers, fill count, pattern registers, scan window and
// result register.
// ----------------------------------------------------------------------------
module bfps_datapath
    import bfps_pkg::*;
#(
    parameter int FIFO_DEPTH  = 512,
    parameter int MAX_PATTERN = 8
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire ctl_cmd_t         cmd,
    input  wire req_t             req,
    input  wire                   cfg_we,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_data,
    output dp_status_t            status,
    output logic                  done,
    output res_t                  result
);

    localparam int PW  = $clog2(FIFO_DEPTH);
    localparam int CW  = $clog2(FIFO_DEPTH + 1);
    localparam int XW  = (CW > PLEN_W) ? CW : PLEN_W;
    localparam int WIW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [BYTE_W-1:0] mem [FIFO_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    logic [PW-1:0]  wp_reg, wp_next;
    logic [PW-1:0]  rp_reg, rp_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [PW-1:0]  scan_ptr_reg, scan_ptr_next;
    logic [CW-1:0]  issue_reg, issue_next;
    logic [CW-1:0]  recv_reg, recv_next;
    logic           pend_reg, pend_next;
    logic [BYTE_W-1:0] window_reg [MAX_PATTERN];
    logic           shift_en;

    logic [PATTERN_W-1:0] pattern_reg;
    logic [PLEN_W-1:0]    plen_reg;
    logic [PLEN_W-1:0]    len_eff;

    logic done_reg;
    logic rvalid_reg, rvalid_next;
    logic acc_reg, acc_next;
    logic found_reg, found_next;

    logic              mem_we;
    logic              mem_re;
    logic [PW-1:0]     mem_raddr;
    logic              match;
    logic [PLEN_W-1:0] widx;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(FIFO_DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    assign len_eff = (plen_reg > PLEN_W'(MAX_PATTERN)) ? PLEN_W'(MAX_PATTERN) : plen_reg;

    // compare the newest len_eff bytes of the window against the pattern
    always_comb
    begin
        match = 1'b1;
        widx  = '0;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            widx = PLEN_W'(len_eff - 1'b1 - PLEN_W'(k));
            if (PLEN_W'(k) < len_eff)
            begin
                if (window_reg[widx[WIW-1:0]] != pattern_reg[BYTE_W*k +: BYTE_W])
                begin
                    match = 1'b0;
                end
            end
        end
    end

    assign status.scan_trivial = (len_eff == '0) || (XW'(len_eff) > XW'(count_reg));
    assign status.scan_hit     = match && (XW'(recv_reg) >= XW'(len_eff));
    assign status.scan_end     = (recv_reg == count_reg);

    always_comb
    begin
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        count_next    = count_reg;
        scan_ptr_next = scan_ptr_reg;
        issue_next    = issue_reg;
        recv_next     = recv_reg;
        pend_next     = 1'b0;
        shift_en      = 1'b0;
        rvalid_next   = rvalid_reg;
        acc_next      = acc_reg;
        found_next    = found_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = rp_reg;
        unique case (cmd.op)
            OP_NONE: ;
            OP_WRITE:
            begin
                rvalid_next = 1'b0;
                found_next  = 1'b0;
                acc_next    = 1'b0;
                if (count_reg != CW'(FIFO_DEPTH))
                begin
                    mem_we     = 1'b1;
                    wp_next    = ptr_inc(wp_reg);
                    count_next = count_reg + 1'b1;
                    acc_next   = 1'b1;
                end
            end
            OP_READ:
            begin
                rvalid_next = 1'b0;
                found_next  = 1'b0;
                acc_next    = 1'b0;
                if (count_reg != '0)
                begin
                    mem_re      = 1'b1;
                    rp_next     = ptr_inc(rp_reg);
                    count_next  = count_reg - 1'b1;
                    rvalid_next = 1'b1;
                end
            end
            OP_FLUSH:
            begin
                rvalid_next = 1'b0;
                found_next  = 1'b0;
                acc_next    = 1'b0;
                wp_next     = '0;
                rp_next     = '0;
                count_next  = '0;
            end
            OP_SCAN_LOAD:
            begin
                scan_ptr_next = rp_reg;
                issue_next    = '0;
                recv_next     = '0;
            end
            OP_SCAN_STEP:
            begin
                if (issue_reg != count_reg)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = scan_ptr_reg;
                    scan_ptr_next = ptr_inc(scan_ptr_reg);
                    issue_next    = issue_reg + 1'b1;
                    pend_next     = 1'b1;
                end
                // take in the byte fetched last cycle
                if (pend_reg)
                begin
                    shift_en  = 1'b1;
                    recv_next = recv_reg + 1'b1;
                end
            end
            OP_FIND_DONE:
            begin
                rvalid_next = 1'b0;
                acc_next    = 1'b0;
                found_next  = cmd.found;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= req.write_byte;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            window_reg[0] <= rdata_reg;
            for (int j = 1; j < MAX_PATTERN; j++)
            begin
                window_reg[j] <= window_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            rp_reg       <= '0;
            count_reg    <= '0;
            scan_ptr_reg <= '0;
            issue_reg    <= '0;
            recv_reg     <= '0;
            pend_reg     <= 1'b0;
            pattern_reg  <= '0;
            plen_reg     <= '0;
            done_reg     <= 1'b0;
            rvalid_reg   <= 1'b0;
            acc_reg      <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            count_reg    <= count_next;
            scan_ptr_reg <= scan_ptr_next;
            issue_reg    <= issue_next;
            recv_reg     <= recv_next;
            pend_reg     <= pend_next;
            done_reg     <= (cmd.op == OP_WRITE) || (cmd.op == OP_READ) ||
                            (cmd.op == OP_FLUSH) || (cmd.op == OP_FIND_DONE);
            rvalid_reg   <= rvalid_next;
            acc_reg      <= acc_next;
            found_reg    <= found_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SEARCH_PATTERN: pattern_reg <= cfg_data[PATTERN_W-1:0];
                    CFG_PATTERN_LENGTH: plen_reg    <= cfg_data[PLEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign done              = done_reg;
    assign result.read_byte  = rvalid_reg ? rdata_reg : '0;
    assign result.read_valid = rvalid_reg;
    assign result.accepted   = acc_reg;
    assign result.found      = found_reg;
    assign result.fill_count = FILL_W'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(FIFO_DEPTH))
        else $error("fill count above depth");

    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $countones({rvalid_reg, acc_reg, found_reg}) <= 1)
        else $error("more than one result flag set");

    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_SCAN_STEP |-> recv_reg <= issue_reg && issue_reg <= count_reg)
        else $error("scan counters out of order");

    a_ptrs_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.op) == OP_SCAN_STEP |-> $stable(rp_reg) && $stable(count_reg))
        else $error("FIFO state changed during a scan");

endmodule

`default_nettype wire

/* design/byte_fifo_with_pattern_search.sv */
`default_nettype none
// Write, read and flush transactions are accepted one per cycle when not busy;
// each result strobes done in the cycle after acceptance and busy stays low.
// A find holds busy while it scans the held bytes through the single store
// read port, one byte per cycle. The result strobe cannot be stalled. Reset
// clears pointers, fill count and pattern registers; store contents are not
// cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Byte FIFO with pattern search - top level
// Circular byte FIFO with write, read, flush and substring find requests.
// ----------------------------------------------------------------------------
module byte_fifo_with_pattern_search
    import bfps_pkg::*;
#(
    parameter int FIFO_DEPTH  = 512,
    parameter int MAX_PATTERN = 8
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    output logic                  busy,
    input  wire req_t             req,
    output logic                  done,
    output res_t                  result,
    input  wire                   cfg_we,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_data
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    bfps_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .req    (req),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    bfps_datapath #(
        .FIFO_DEPTH  (FIFO_DEPTH),
        .MAX_PATTERN (MAX_PATTERN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .done      (done),
        .result    (result)
    );

endmodule

`default_nettype wire

/* sim/fifo_search_checker.sv */
// ----------------------------------------------------------------------------
// Byte FIFO with pattern search - transaction checker
// Keeps its own copy of the FIFO and the search registers. It updates that
// copy from every accepted request and register write, predicts each
// result, and compares the strobed results field by field, oldest first.
// ----------------------------------------------------------------------------
module fifo_search_checker
    import bfps_pkg::*;
#(
    parameter int FIFO_DEPTH  = 512,
    parameter int MAX_PATTERN = 8
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    input  wire                   busy,
    input  req_t                  req,
    input  wire                   done,
    input  res_t                  result,
    input  wire                   cfg_we,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_data,
    output int                    mismatches,
    output int                    pending
);

    localparam int PRINT_LIMIT = 40;

    logic [BYTE_W-1:0]    fifo_bytes [FIFO_DEPTH];
    int                   head;
    int                   tail;
    int                   held;
    logic [PATTERN_W-1:0] pattern;
    logic [PLEN_W-1:0]    pattern_len;
    res_t                 expected_results [$];

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t: mismatch: %s", $time, msg);
    endtask

    // Scan the unread bytes from the oldest one onward.
    function automatic logic pattern_in_fifo();
        int   len;
        logic hit;
        len = (int'(pattern_len) > MAX_PATTERN) ? MAX_PATTERN : int'(pattern_len);
        if (len == 0 || len > held)
            return 1'b0;
        for (int s = 0; s + len <= held; s++)
        begin
            hit = 1'b1;
            for (int k = 0; k < len; k++)
            begin
                if (fifo_bytes[(head + s + k) % FIFO_DEPTH] != pattern[8*k +: 8])
                    hit = 1'b0;
            end
            if (hit)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one request to the FIFO copy and return the result it causes.
    function automatic res_t fifo_response(input req_t r);
        res_t o;
        o = '0;
        case (r.req_type)
            REQ_WRITE:
                if (held < FIFO_DEPTH)
                begin
                    fifo_bytes[tail] = r.write_byte;
                    tail = (tail + 1) % FIFO_DEPTH;
                    held++;
                    o.accepted = 1'b1;
                end
            REQ_READ:
                if (held > 0)
                begin
                    o.read_byte = fifo_bytes[head];
                    o.read_valid = 1'b1;
                    head = (head + 1) % FIFO_DEPTH;
                    held--;
                end
            REQ_FLUSH:
            begin
                head = 0;
                tail = 0;
                held = 0;
            end
            REQ_FIND:
                o.found = pattern_in_fifo();
            default:
            begin
            end
        endcase
        o.fill_count = FILL_W'(held);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            head = 0;
            tail = 0;
            held = 0;
            pattern = '0;
            pattern_len = '0;
            mismatches = 0;
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_SEARCH_PATTERN)
                    pattern = cfg_data;
                else if (cfg_index == CFG_PATTERN_LENGTH)
                    pattern_len = cfg_data[PLEN_W-1:0];
            end
            if (start && !busy)
                expected_results.push_back(fifo_response(req));
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result strobed with no transaction outstanding");
                else
                begin
                    want = expected_results.pop_front();
                    if (result.read_byte !== want.read_byte)
                        report_mismatch($sformatf("read_byte %0h, expected %0h",
                                                  result.read_byte, want.read_byte));
                    if (result.read_valid !== want.read_valid)
                        report_mismatch($sformatf("read_valid %0b, expected %0b",
                                                  result.read_valid, want.read_valid));
                    if (result.accepted !== want.accepted)
                        report_mismatch($sformatf("accepted %0b, expected %0b",
                                                  result.accepted, want.accepted));
                    if (result.found !== want.found)
                        report_mismatch($sformatf("found %0b, expected %0b",
                                                  result.found, want.found));
                    if (result.fill_count !== want.fill_count)
                        report_mismatch($sformatf("fill_count %0d, expected %0d",
                                                  result.fill_count, want.fill_count));
                end
            end
            pending <= expected_results.size();
        end
    end

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// Byte FIFO with pattern search - testbench top
// Drives a short directed sequence, then random phases under several search
// settings: mixed traffic, a fill past full, a drain with wrap-around, and short
// and full-length patterns. Requests go out in bursts with random gaps, but for
// the drain; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import bfps_pkg::*;

    localparam int FIFO_DEPTH  = 512;
    localparam int MAX_PATTERN = 8;
    localparam int QUIET_LIMIT = 4000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    req_t                  req = '0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  busy;
    logic                  done;
    res_t                  result;
    int                    mismatches;
    int                    pending;
    int                    quiet_cycles = 0;

    // Stimulus copy of the search setting, used to build matching byte runs
    logic [PATTERN_W-1:0]  pattern_now = '0;
    int                    run_len = 0;
    int                    run_pos = 0;

    always #6 clk = ~clk;

    byte_fifo_with_pattern_search #(
        .FIFO_DEPTH  (FIFO_DEPTH),
        .MAX_PATTERN (MAX_PATTERN)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fifo_search_checker #(
        .FIFO_DEPTH  (FIFO_DEPTH),
        .MAX_PATTERN (MAX_PATTERN)
    ) fifo_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .result     (result),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Count cycles with no transaction in either direction
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Upper bits of the length write are noise; only the low nibble counts.
    task automatic configure_search(input logic [PATTERN_W-1:0] pat,
                                    input logic [PLEN_W-1:0] len);
        logic [CFG_DATA_W-1:0] value;
        value = {$urandom, $urandom};
        value[PLEN_W-1:0] = len;
        set_register(CFG_SEARCH_PATTERN, pat);
        set_register(CFG_PATTERN_LENGTH, value);
        pattern_now = pat;
        run_len = (int'(len) > MAX_PATTERN) ? MAX_PATTERN : int'(len);
        run_pos = 0;
    endtask

    task automatic issue(input logic [1:0] kind, input logic [BYTE_W-1:0] data);
        req_t r;
        r.req_type = kind;
        r.write_byte = data;
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drop start and hold until every result is back.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly pattern runs, sometimes cut short, otherwise random bytes.
    function automatic logic [BYTE_W-1:0] next_write_byte();
        logic [BYTE_W-1:0] b;
        if (run_len > 0 && (run_pos > 0 || $urandom_range(0, 2) == 0)
            && $urandom_range(0, 15) != 0)
        begin
            b = pattern_now[8*run_pos +: 8];
            run_pos = (run_pos + 1 == run_len) ? 0 : run_pos + 1;
        end
        else
        begin
            b = BYTE_W'($urandom);
            run_pos = 0;
        end
        return b;
    endfunction

    task automatic run_phase(input int items, input int w_write, input int w_read,
                             input int w_flush, input int w_find, input bit with_gaps);
        int         burst;
        int         gap;
        int         pick;
        logic [1:0] kind;
        burst = $urandom_range(1, 20);
        for (int i = 0; i < items; i++)
        begin
            pick = $urandom_range(0, w_write + w_read + w_flush + w_find - 1);
            if (pick < w_write)
                kind = REQ_WRITE;
            else if (pick < w_write + w_read)
                kind = REQ_READ;
            else if (pick < w_write + w_read + w_flush)
                kind = REQ_FLUSH;
            else
                kind = REQ_FIND;
            issue(kind, (kind == REQ_WRITE) ? next_write_byte() : BYTE_W'($urandom));
            burst--;
            if (with_gaps && burst <= 0)
            begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 5);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
                burst = $urandom_range(1, 20);
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: pattern 00 FF, upper pattern bytes must be ignored
        configure_search(64'hA5C3_0F96_1234_FF00, 4'd2);
        issue(REQ_READ, 8'hFF);
        issue(REQ_FIND, 8'h00);
        issue(REQ_WRITE, 8'h00);
        issue(REQ_FIND, 8'h00);
        issue(REQ_WRITE, 8'hFF);
        issue(REQ_FIND, 8'h00);
        issue(REQ_WRITE, 8'h5A);
        issue(REQ_READ, 8'h00);
        issue(REQ_FIND, 8'hFF);
        issue(REQ_WRITE, 8'h00);
        issue(REQ_WRITE, 8'hFF);
        issue(REQ_FIND, 8'h00);
        issue(REQ_FLUSH, 8'hFF);
        issue(REQ_READ, 8'h00);
        issue(REQ_FIND, 8'h00);
        issue(REQ_WRITE, 8'hFF);
        issue(REQ_READ, 8'h00);
        settle();

        configure_search({$urandom, $urandom}, 4'd3);
        run_phase(200, 45, 35, 2, 18, 1'b1);
        settle();

        // Fill past full; length above the maximum saturates
        configure_search('1, 4'd15);
        run_phase(560, 96, 0, 0, 4, 1'b1);
        settle();

        // Drain across the wrap point; zero length never finds
        configure_search('0, 4'd0);
        run_phase(200, 30, 55, 0, 15, 1'b0);
        settle();

        configure_search({$urandom, $urandom}, 4'd1);
        run_phase(150, 40, 40, 5, 15, 1'b1);
        settle();

        configure_search({$urandom, $urandom}, 4'd8);
        run_phase(150, 50, 30, 3, 17, 1'b1);
        settle();

        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
